// ===== sv/ipv4_prefix_block_table_assert.svh =====
`ifndef IPV4_PREFIX_BLOCK_TABLE_ASSERT_SVH
`define IPV4_PREFIX_BLOCK_TABLE_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define IPBT_ASSERT_ALWAYS(lbl, clk, rst, p) \
  lbl: assert property (@(posedge clk) disable iff (rst) (p)) \
    else $error("assertion failed");

// Same-cycle implication.
`define IPBT_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication.
`define IPBT_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== sv/ipbt_pkg.sv =====
package ipbt_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam int KIND_W = 2;
  localparam int ADDR_W = 32;
  localparam int PLEN_W = 8;
  localparam int LEN_W = 6;
  localparam int ENTRY_COUNT_W = 8;
  localparam int ENTRY_W = ADDR_W + LEN_W;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ENABLED = 2'd0;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0] len_t;

  function automatic addr_t prefix_mask(len_t len);
    addr_t m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

// ===== sv/ipbt_if.sv =====
interface ipbt_req_if;
  logic                          valid;
  logic                          ready;
  logic [ipbt_pkg::KIND_W-1:0]   kind;
  logic [ipbt_pkg::ADDR_W-1:0]   address;
  logic [ipbt_pkg::PLEN_W-1:0]   prefix_len;

  modport source (output valid, kind, address, prefix_len, input ready);
  modport sink (input valid, kind, address, prefix_len, output ready);
endinterface

interface ipbt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               drop;
  logic                               rejected;
  logic [ipbt_pkg::ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, drop, rejected, entry_count, input ready);
  modport sink (input valid, drop, rejected, entry_count, output ready);
endinterface

// ===== sv/ipbt_ram.sv =====
module ipbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ipv4_prefix_block_table.sv =====
// IPv4 prefix blocklist. Requests come in on req: clear empties the table, add appends an
// address with its prefix length (lengths above 32 clamp to 32; rejected is set when the
// table is full or the block is disabled), lookup reports drop when the destination matches
// any stored prefix (length 0 matches every address). One result per request leaves on rsp,
// through an output register, so a new request is taken while a result waits. A clear, an
// add or an unused kind goes from accept to the done state and then into the output register
// once that is free. A lookup walks the stored entries one per cycle through the entry RAM's
// single read port and one mask compare, and stops at the first match. Requests are taken one
// at a time. The enabled register sits at APB address 0 (bit 0); enabled = 0 makes lookups
// report no drop.
module ipv4_prefix_block_table (
  input  logic                           clk,
  input  logic                           rst,
  ipbt_req_if.sink                       req,
  ipbt_rsp_if.source                     rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ipbt_pkg::PADDR_W-1:0]   paddr,
  input  logic [ipbt_pkg::PDATA_W-1:0]   pwdata,
  output logic [ipbt_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import ipbt_pkg::*;

  `include "ipv4_prefix_block_table_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic             enabled;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ridx;
  logic             cmp_valid;
  addr_t            lk_addr;
  logic             res_drop;
  logic             res_rejected;

  logic             out_valid;
  logic             out_drop;
  logic             out_rejected;
  logic [ENTRY_COUNT_W-1:0] out_count;

  logic             accept;
  logic             add_ok;
  logic             ram_we;
  logic             ram_re;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  len_t             add_len;
  len_t             ent_len;
  addr_t            ent_addr;
  logic             match;
  logic             out_free;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ENABLED) ? {{(PDATA_W-1){1'b0}}, enabled} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_ENABLED) begin
      enabled <= pwdata[0];
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign accept = req.valid && req.ready;
  assign add_ok = enabled && (count < CNT_W'(MAX_ENTRIES));

  // clamp raw length to 32
  assign add_len = (req.prefix_len > PLEN_W'(MAX_LEN)) ? MAX_LEN : req.prefix_len[LEN_W-1:0];

  assign ram_we = accept && req.kind == KIND_ADD && add_ok;
  assign ram_wdata = {add_len, req.address};
  assign ram_re = (state == ST_SCAN) && (ridx < count);

  ipbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ridx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ent_addr = ram_rdata[ADDR_W-1:0];
  assign ent_len = ram_rdata[ENTRY_W-1:ADDR_W];
  assign match = ((lk_addr ^ ent_addr) & prefix_mask(ent_len)) == '0;

  assign out_free = !out_valid || rsp.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ridx <= '0;
      cmp_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_drop <= 1'b0;
            res_rejected <= 1'b0;
            state <= ST_DONE;
            case (req.kind)
              KIND_CLEAR: begin
                count <= '0;
              end
              KIND_ADD: begin
                if (add_ok) begin
                  count <= count + 1'b1;
                end else begin
                  res_rejected <= 1'b1;
                end
              end
              KIND_LOOKUP: begin
                lk_addr <= req.address;
                ridx <= '0;
                cmp_valid <= 1'b0;
                if (enabled && count != '0) begin
                  state <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (ram_re) begin
            ridx <= ridx + 1'b1;
          end
          cmp_valid <= ram_re;
          if (cmp_valid && match) begin
            res_drop <= 1'b1;
            cmp_valid <= 1'b0;
            state <= ST_DONE;
          end else if (!cmp_valid && ridx == count) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
        out_drop <= res_drop;
        out_rejected <= res_rejected;
        out_count <= ENTRY_COUNT_W'(count);
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.drop = out_drop;
  assign rsp.rejected = out_rejected;
  assign rsp.entry_count = out_count;

  `IPBT_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(MAX_ENTRIES))
  `IPBT_ASSERT_IMPL(a_scan_bound, clk, rst, state == ST_SCAN, ridx <= count)
  `IPBT_ASSERT_IMPL(a_drop_rej_excl, clk, rst, out_valid, !(out_drop && out_rejected))
  `IPBT_ASSERT_NEXT(a_add_grows, clk, rst, ram_we, count == CNT_W'($past(count) + 1'b1))

endmodule

// ===== tb/ipv4_prefix_block_table_tb.sv =====
module ipv4_prefix_block_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipbt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                     drop;
    logic                     rejected;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } verdict_t;

  typedef enum bit {ROW_REQUEST, ROW_ENABLE} row_op_t;

  typedef struct packed {
    row_op_t           op;
    bit                en_value;
    logic [KIND_W-1:0] kind;
    addr_t             address;
    logic [PLEN_W-1:0] plen;
    bit                typed;
    verdict_t          verdict;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ipbt_req_if req_ch ();
  ipbt_rsp_if rsp_ch ();

  ipv4_prefix_block_table dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Shadow copy of the blocklist
  addr_t tbl_addr [MAX_ENTRIES];
  len_t  tbl_len [MAX_ENTRIES];
  int    tbl_count = 0;
  bit    blk_enabled = 1'b0;

  verdict_t pending_verdicts [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int stall_cycles = 0;

  function automatic addr_t len_mask(input int len);
    if (len == 0) begin
      return '0;
    end
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

  function automatic verdict_t predict_verdict(input logic [KIND_W-1:0] kind, input addr_t a,
                                               input logic [PLEN_W-1:0] plen);
    verdict_t v;
    addr_t m;
    v = '0;
    case (kind)
      KIND_CLEAR: begin
        tbl_count = 0;
      end
      KIND_ADD: begin
        if (!blk_enabled || tbl_count >= MAX_ENTRIES) begin
          v.rejected = 1'b1;
        end else begin
          tbl_addr[tbl_count] = a;
          tbl_len[tbl_count] = (plen > 8'd32) ? len_t'(32) : len_t'(plen);
          tbl_count++;
        end
      end
      KIND_LOOKUP: begin
        if (blk_enabled) begin
          for (int i = 0; i < tbl_count; i++) begin
            m = len_mask(tbl_len[i]);
            if ((a & m) == (tbl_addr[i] & m)) begin
              v.drop = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    v.entry_count = ENTRY_COUNT_W'(tbl_count);
    return v;
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input addr_t a,
                              input logic [PLEN_W-1:0] plen, input bit typed,
                              input verdict_t typed_verdict);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.address <= a;
    req_ch.prefix_len <= plen;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    v = predict_verdict(kind, a, plen);
    pending_verdicts.push_back(typed ? typed_verdict : v);
  endtask

  // Hold off until every expected result is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_enable(input bit value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_ENABLED;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    blk_enabled = value;
  endtask

  function automatic logic [PLEN_W-1:0] random_plen();
    int r;
    r = $urandom_range(0, 99);
    if (r < 1) begin
      return 8'd0;
    end else if (r < 12) begin
      return PLEN_W'($urandom_range(33, 255));
    end
    return PLEN_W'($urandom_range(1, 32));
  endfunction

  function automatic addr_t lookup_address();
    int r, j, b;
    addr_t m, a;
    r = $urandom_range(0, 99);
    a = $urandom;
    if (tbl_count > 0 && r < 75) begin
      j = $urandom_range(0, tbl_count - 1);
      m = len_mask(tbl_len[j]);
      a = (tbl_addr[j] & m) | (a & ~m);
      // flip one prefix bit for a near miss
      if (r >= 50 && tbl_len[j] != 0) begin
        b = $urandom_range(ADDR_W - tbl_len[j], ADDR_W - 1);
        a = a ^ (addr_t'(1) << b);
      end
    end
    return a;
  endfunction

  task automatic send_noise();
    send_request(KIND_W'($urandom_range(0, 3)), $urandom, PLEN_W'($urandom), 1'b0, '0);
  endtask

  localparam int DIR_ROWS = 27;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd0}},
    '{ROW_REQUEST, 1'b0, KIND_ADD,    32'h0A00_0000, 8'd8,   1'b1, '{1'b0, 1'b1, 8'd0}},
    '{ROW_REQUEST, 1'b0, KIND_CLEAR,  32'h0000_0000, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd0}},
    '{ROW_REQUEST, 1'b0, KIND_UNUSED, 32'h0000_0000, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd0}},
    '{ROW_ENABLE,  1'b1, KIND_CLEAR,  32'h0000_0000, 8'd0,   1'b0, '0},
    '{ROW_REQUEST, 1'b0, KIND_ADD,    32'hC0A8_0000, 8'd16,  1'b1, '{1'b0, 1'b0, 8'd1}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'hC0A8_1234, 8'd0,   1'b1, '{1'b1, 1'b0, 8'd1}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'hC0A9_0000, 8'd0,   1'b0, '0},
    '{ROW_REQUEST, 1'b0, KIND_ADD,    32'h0102_0304, 8'd255, 1'b1, '{1'b0, 1'b0, 8'd2}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'h0102_0304, 8'd0,   1'b1, '{1'b1, 1'b0, 8'd2}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'h0102_0305, 8'd0,   1'b0, '0},
    '{ROW_REQUEST, 1'b0, KIND_ADD,    32'hFFFF_FFFF, 8'd33,  1'b1, '{1'b0, 1'b0, 8'd3}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b1, 1'b0, 8'd3}},
    '{ROW_REQUEST, 1'b0, KIND_UNUSED, 32'hFFFF_FFFF, 8'd255, 1'b1, '{1'b0, 1'b0, 8'd3}},
    '{ROW_ENABLE,  1'b0, KIND_CLEAR,  32'h0000_0000, 8'd0,   1'b0, '0},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'hC0A8_1234, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd3}},
    '{ROW_REQUEST, 1'b0, KIND_ADD,    32'h5555_AAAA, 8'd20,  1'b1, '{1'b0, 1'b1, 8'd3}},
    '{ROW_REQUEST, 1'b0, KIND_CLEAR,  32'hFFFF_FFFF, 8'd255, 1'b1, '{1'b0, 1'b0, 8'd0}},
    '{ROW_ENABLE,  1'b1, KIND_CLEAR,  32'h0000_0000, 8'd0,   1'b0, '0},
    '{ROW_REQUEST, 1'b0, KIND_ADD,    32'h1234_5678, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd1}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'h0000_0000, 8'd0,   1'b1, '{1'b1, 1'b0, 8'd1}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b1, 1'b0, 8'd1}},
    '{ROW_REQUEST, 1'b0, KIND_CLEAR,  32'h0000_0000, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd0}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'h8000_0000, 8'd0,   1'b1, '{1'b0, 1'b0, 8'd0}},
    '{ROW_REQUEST, 1'b0, KIND_ADD,    32'h8000_0000, 8'd1,   1'b1, '{1'b0, 1'b0, 8'd1}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b1, 1'b0, 8'd1}},
    '{ROW_REQUEST, 1'b0, KIND_LOOKUP, 32'h7FFF_FFFF, 8'd0,   1'b0, '0}
  };

  initial begin
    int sent, phase, fill, lookups;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_CLEAR;
    req_ch.address = '0;
    req_ch.prefix_len = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_ENABLE) begin
        drain_results();
        write_enable(dir_rows[i].en_value);
      end else begin
        send_request(dir_rows[i].kind, dir_rows[i].address, dir_rows[i].plen,
                     dir_rows[i].typed, dir_rows[i].verdict);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      write_enable(phase % 6 != 5);
      if ($urandom_range(0, 3) != 0) begin
        send_request(KIND_CLEAR, $urandom, PLEN_W'($urandom), 1'b0, '0);
        sent++;
      end
      // some phases overfill the table to reach the full case
      fill = (phase % 5 == 3) ? $urandom_range(126, 132) : $urandom_range(0, 24);
      repeat (fill) begin
        if ($urandom_range(0, 19) == 0) begin
          send_noise();
        end else begin
          send_request(KIND_ADD, $urandom, random_plen(), 1'b0, '0);
        end
        sent++;
      end
      lookups = $urandom_range(10, 40);
      repeat (lookups) begin
        if ($urandom_range(0, 14) == 0) begin
          send_noise();
        end else begin
          send_request(KIND_LOOKUP, lookup_address(), PLEN_W'($urandom), 1'b0, '0);
        end
        sent++;
      end
      phase++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result: drop %0d rejected %0d entry_count %0d",
                 rsp_ch.drop, rsp_ch.rejected, rsp_ch.entry_count);
          mismatch_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (rsp_ch.drop !== want.drop) begin
            $error("drop: expected %0d, got %0d", want.drop, rsp_ch.drop);
            mismatch_count++;
          end
          if (rsp_ch.rejected !== want.rejected) begin
            $error("rejected: expected %0d, got %0d", want.rejected, rsp_ch.rejected);
            mismatch_count++;
          end
          if (rsp_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   rsp_ch.entry_count);
            mismatch_count++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ipbt_pkg.sv
sv/ipbt_if.sv
sv/ipbt_ram.sv
sv/ipv4_prefix_block_table.sv
tb/ipv4_prefix_block_table_tb.sv
